FILE: hdl/opd_pkg.sv
// opd_pkg: shared constants and beat types for the order preserving dedup block
// no dependencies; used by every module under hdl
package opd_pkg;

	localparam int STORE_DEPTH = 64;
	localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
	localparam int UCNT_W      = 7;

	localparam logic [CNT_W+UCNT_W-1:0] DEPTH_EXT = (CNT_W + UCNT_W)'(STORE_DEPTH);
	localparam logic [UCNT_W-1:0]       FULL_CODE = DEPTH_EXT[UCNT_W-1:0];

	typedef struct packed {
		logic signed [31:0] element_value;
		logic               last_item;
	} item_beat_t;

	typedef struct packed {
		logic signed [31:0] value_out;
		logic               is_new;
		logic [UCNT_W-1:0]  unique_count;
		logic               end_of_set;
		logic               overflow;
	} result_beat_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic               last;
		logic               found;
		logic               claimed;
		logic [CNT_W-1:0]   count;
	} slot_t;

	function automatic logic [UCNT_W-1:0] low_count(input logic [CNT_W-1:0] cnt);
		logic [CNT_W+UCNT_W-1:0] ext;
		ext = {{UCNT_W{1'b0}}, cnt};
		return ext[UCNT_W-1:0];
	endfunction

endpackage

FILE: hdl/opd_cell.sv
// opd_cell: one stage of the dedup chain, holding a single stored value
// depends on opd_pkg for the slot type and count width
module opd_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,
	input  logic          up_vld,
	input  opd_pkg::slot_t up,
	output logic          dn_vld,
	output opd_pkg::slot_t dn
);

	logic signed [31:0] stored_q;
	logic               occ_q;
	logic               vld_q;
	opd_pkg::slot_t     slot_q;
	logic               hit;
	logic               take;
	opd_pkg::slot_t     slot_nxt;

	always_comb begin
		hit  = occ_q && (stored_q == up.value);
		take = up_vld && !up.found && !up.claimed && !occ_q;
		slot_nxt         = up;
		slot_nxt.found   = up.found || hit;
		slot_nxt.claimed = up.claimed || take;
		slot_nxt.count   = (occ_q || take) ? up.count + opd_pkg::CNT_W'(1) : up.count;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			occ_q <= 1'b0;
		end else if (advance) begin
			vld_q <= up_vld;
			if (up_vld && up.last) begin
				occ_q <= 1'b0;
			end else if (take) begin
				occ_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			slot_q <= slot_nxt;
			if (take) begin
				stored_q <= up.value;
			end
		end
	end

	assign dn_vld = vld_q;
	assign dn     = slot_q;

endmodule

FILE: hdl/order_preserving_dedup.sv
// order_preserving_dedup: beats pass through STORE_DEPTH registered cells in a chain
// throughput one beat per cycle unless the result stalls; the cells advance together
// a stalled result freezes the whole chain and stalls the item side in the same cycle
// reset clears every cell's occupancy and every stage valid; stored values need no reset
// depends on opd_pkg and opd_cell
module order_preserving_dedup (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  opd_pkg::item_beat_t   item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output opd_pkg::result_beat_t result
);

	localparam int D = opd_pkg::STORE_DEPTH;

	logic           advance;
	logic           vld_chain  [0:D];
	opd_pkg::slot_t slot_chain [0:D];

	assign advance    = !result_valid || !result_stall;
	assign item_stall = !advance;

	assign vld_chain[0]  = item_valid;
	assign slot_chain[0] = '{
		value:   item.element_value,
		last:    item.last_item,
		found:   1'b0,
		claimed: 1'b0,
		count:   '0
	};

	for (genvar i = 0; i < D; i++) begin : g_cell
		opd_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.up_vld  (vld_chain[i]),
			.up      (slot_chain[i]),
			.dn_vld  (vld_chain[i+1]),
			.dn      (slot_chain[i+1])
		);
	end

	always_comb begin
		result_valid        = vld_chain[D];
		result.value_out    = slot_chain[D].value;
		result.is_new       = slot_chain[D].claimed;
		result.unique_count = opd_pkg::low_count(slot_chain[D].count);
		result.end_of_set   = slot_chain[D].last;
		result.overflow     = !slot_chain[D].found && !slot_chain[D].claimed;
	end

endmodule

FILE: hdl/opd_checker.sv
// opd_checker: port level checks for order_preserving_dedup, bound to the top level
// depends on opd_pkg for the beat types and the full store code
module opd_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  item_valid,
	input logic                  item_stall,
	input opd_pkg::item_beat_t   item,
	input logic                  result_valid,
	input logic                  result_stall,
	input opd_pkg::result_beat_t result
);

	a_item_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_stall |=> item_valid && $stable(item))
		else $error("item beat changed while stalled");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result beat changed while stalled");

	a_stall_link: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall == (result_valid && result_stall))
		else $error("item stall does not follow a held result");

	a_new_or_over: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.is_new && result.overflow))
		else $error("beat both new and overflowed");

	a_over_full: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.overflow |-> result.unique_count == opd_pkg::FULL_CODE)
		else $error("overflow with store not full");

endmodule

bind order_preserving_dedup opd_checker u_opd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.item         (item),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
